[src/pfs_pkg.sv]
// Shared types, constants and the helper function of the periodic frame scheduler.
`default_nettype none

package pfs_pkg;

  // Default number of table slots
  localparam int unsigned TableDepth = 32;

  // Stream widths (payload rounded up to whole bytes)
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 104;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned IdW     = 29;
  localparam int unsigned DlcW    = 4;
  localparam int unsigned DataW   = 64;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutIdxW = 5;

  // Result kinds
  localparam logic [KindW-1:0] KindAccept = 2'd0;
  localparam logic [KindW-1:0] KindRefuse = 2'd1;
  localparam logic [KindW-1:0] KindFrame  = 2'd2;

  // Input action codes (carried on tuser)
  localparam logic ActionLoad = 1'b0;
  localparam logic ActionTick = 1'b1;

  // Static part of a table entry: counter config, period, DLC, identifier
  typedef struct packed {
    logic [CfgW-1:0]    cfg;
    logic [PeriodW-1:0] period;
    logic [DlcW-1:0]    dlc;
    logic [IdW-1:0]     id;
  } entry_t;

  // Changing part of a table entry: last send time and data bytes
  typedef struct packed {
    logic [TimeW-1:0] last_sent;
    logic [DataW-1:0] data;
  } dyn_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic             is_tick;
    logic [TimeW-1:0] now;
    entry_t           entry;
    logic [DataW-1:0] data;
  } cmd_t;

  // Advance the rolling counter field of one data byte.
  // cfg: enable [0], byte [3:1], shift [6:4], width [10:7].
  function automatic logic [DataW-1:0] advance_counter(input logic [DataW-1:0] data,
                                                       input logic [CfgW-1:0]  cfg);
    logic [2:0]       bsel;
    logic [2:0]       shift;
    logic [3:0]       width;
    logic [8:0]       ones;
    logic [15:0]      wide;
    logic [7:0]       mask;
    logic [7:0]       fmask;
    logic [7:0]       byte_v;
    logic [7:0]       cnt;
    logic [DataW-1:0] res;
    bsel  = cfg[3:1];
    shift = cfg[6:4];
    width = cfg[10:7];
    if (width > 4'd8) width = 4'd8;
    ones   = (9'd1 << width) - 9'd1;
    wide   = {7'd0, ones} << shift;
    mask   = wide[7:0];
    fmask  = mask >> shift;
    byte_v = data[{bsel, 3'b000} +: 8];
    cnt    = (((byte_v & mask) >> shift) + 8'd1) & fmask;
    res    = data;
    res[{bsel, 3'b000} +: 8] = (byte_v & ~mask) | (cnt << shift);
    return cfg[0] ? res : data;
  endfunction

endpackage

`default_nettype wire

[src/pfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/pfs_front.sv]
// Front part: accepts input items, classifies them and queues commands.
`default_nettype none

module pfs_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [pfs_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire logic                           s_axis_tuser,
  output logic                                cmd_valid_o,
  input  wire logic                           cmd_ready_i,
  output pfs_pkg::cmd_t                       cmd_o
);

  import pfs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       in_cmd;
  logic       push, pop;

  // Classify the incoming item into a command
  always_comb begin
    in_cmd.is_tick      = (s_axis_tuser == ActionTick);
    in_cmd.now          = s_axis_tdata[31:0];
    in_cmd.entry.id     = s_axis_tdata[60:32];
    in_cmd.entry.dlc    = s_axis_tdata[64:61];
    in_cmd.data         = s_axis_tdata[128:65];
    in_cmd.entry.period = s_axis_tdata[144:129];
    in_cmd.entry.cfg    = s_axis_tdata[155:145];
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign cmd_o         = slot_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  // Advance queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the command payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

[src/pfs_back.sv]
// Back part: executes loads and walks the table on ticks, drives the result stream.
`default_nettype none

module pfs_back #(
  parameter int unsigned TableDepth = pfs_pkg::TableDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_ready_o,
  input  wire pfs_pkg::cmd_t                  cmd_i,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [pfs_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic [pfs_pkg::KindW-1:0]           m_axis_tuser,
  output logic                                m_axis_tlast
);

  import pfs_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    scan_q, scan_d;
  logic               ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]    ev_idx_q, ev_idx_d;
  logic [TimeW-1:0]   now_q, now_d;

  // Held frame, waiting to learn whether it is the final one
  logic               pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]    pend_idx_q, pend_idx_d;
  logic [IdW-1:0]     pend_id_q, pend_id_d;
  logic [DlcW-1:0]    pend_dlc_q, pend_dlc_d;
  logic [DataW-1:0]   pend_data_q, pend_data_d;

  // Output register
  logic               out_vld_q, out_vld_d;
  logic [KindW-1:0]   out_kind_q, out_kind_d;
  logic [OutIdxW-1:0] out_idx_q, out_idx_d;
  logic [IdW-1:0]     out_id_q, out_id_d;
  logic [DlcW-1:0]    out_dlc_q, out_dlc_d;
  logic [DataW-1:0]   out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  // Memory ports
  logic               a_we, b_we, rd_en;
  logic [IdxW-1:0]    a_waddr, b_waddr, raddr;
  entry_t             a_wdata, a_rdata;
  dyn_t               b_wdata, b_rdata;

  logic               out_free;
  logic               is_due;
  logic [TimeW-1:0]   due_time;
  logic [DataW-1:0]   next_data;
  logic               stall;

  pfs_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  pfs_ram #(
    .Width ($bits(dyn_t)),
    .Depth (TableDepth)
  ) u_dyn_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (b_rdata)
  );

  // Evaluate the entry whose record was just read
  assign due_time  = b_rdata.last_sent + {{(TimeW - PeriodW){1'b0}}, a_rdata.period};
  assign is_due    = ev_vld_q && (now_q >= due_time);
  assign next_data = advance_counter(b_rdata.data, a_rdata.cfg);
  assign out_free  = !out_vld_q || m_axis_tready;
  assign stall     = is_due && pend_vld_q && !out_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    now_d       = now_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    pend_id_d   = pend_id_q;
    pend_dlc_d  = pend_dlc_q;
    pend_data_d = pend_data_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_idx_d   = out_idx_q;
    out_id_d    = out_id_q;
    out_dlc_d   = out_dlc_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    cmd_ready_o = 1'b0;
    a_we        = 1'b0;
    a_waddr     = cnt_q[IdxW-1:0];
    a_wdata     = cmd_i.entry;
    b_we        = 1'b0;
    b_waddr     = cnt_q[IdxW-1:0];
    b_wdata     = {{TimeW{1'b0}}, cmd_i.data};
    rd_en       = 1'b0;
    raddr       = scan_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.is_tick) begin
            // Start a walk over the loaded entries
            now_d    = cmd_i.now;
            scan_d   = '0;
            ev_vld_d = 1'b0;
            state_d  = StScan;
          end else begin
            // Append an entry, or refuse when full
            out_vld_d  = 1'b1;
            out_id_d   = '0;
            out_dlc_d  = '0;
            out_data_d = '0;
            out_last_d = 1'b1;
            if (cnt_q == CntW'(TableDepth)) begin
              out_kind_d = KindRefuse;
              out_idx_d  = '0;
            end else begin
              a_we       = 1'b1;
              b_we       = 1'b1;
              out_kind_d = KindAccept;
              out_idx_d  = OutIdxW'(cnt_q[IdxW-1:0]);
              cnt_d      = cnt_q + CntW'(1);
            end
          end
        end
      end

      StScan: begin
        if (!stall) begin
          if (is_due) begin
            // Write back the advanced data and send time
            b_we    = 1'b1;
            b_waddr = ev_idx_q;
            b_wdata = {now_q, next_data};
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_kind_d = KindFrame;
              out_idx_d  = OutIdxW'(pend_idx_q);
              out_id_d   = pend_id_q;
              out_dlc_d  = pend_dlc_q;
              out_data_d = pend_data_q;
              out_last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_idx_d  = ev_idx_q;
            pend_id_d   = a_rdata.id;
            pend_dlc_d  = a_rdata.dlc;
            pend_data_d = next_data;
          end
          // Issue the next read, or finish the walk
          if (scan_q < cnt_q) begin
            rd_en    = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = scan_q[IdxW-1:0];
            scan_d   = scan_q + CntW'(1);
          end else begin
            ev_vld_d = 1'b0;
            if (!ev_vld_q) begin
              state_d = StFlush;
            end
          end
        end
      end

      StFlush: begin
        // Release the held frame as the final one
        if (!pend_vld_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KindFrame;
          out_idx_d  = OutIdxW'(pend_idx_q);
          out_id_d   = pend_id_q;
          out_dlc_d  = pend_dlc_q;
          out_data_d = pend_data_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      scan_q      <= '0;
      ev_vld_q    <= 1'b0;
      ev_idx_q    <= '0;
      now_q       <= '0;
      pend_vld_q  <= 1'b0;
      pend_idx_q  <= '0;
      pend_id_q   <= '0;
      pend_dlc_q  <= '0;
      pend_data_q <= '0;
      out_vld_q   <= 1'b0;
      out_kind_q  <= KindAccept;
      out_idx_q   <= '0;
      out_id_q    <= '0;
      out_dlc_q   <= '0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      ev_vld_q    <= ev_vld_d;
      ev_idx_q    <= ev_idx_d;
      now_q       <= now_d;
      pend_vld_q  <= pend_vld_d;
      pend_idx_q  <= pend_idx_d;
      pend_id_q   <= pend_id_d;
      pend_dlc_q  <= pend_dlc_d;
      pend_data_q <= pend_data_d;
      out_vld_q   <= out_vld_d;
      out_kind_q  <= out_kind_d;
      out_idx_q   <= out_idx_d;
      out_id_q    <= out_id_d;
      out_dlc_q   <= out_dlc_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  // Drive the result stream from the output register
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_data_q, out_dlc_q, out_id_q, out_idx_q};

endmodule

`default_nettype wire

[src/periodic_frame_scheduler.sv]
// A load result is registered in the output register once the back part takes the command from the front queue.
// A tick over N loaded entries (N >= 1) reads one entry per cycle from the table RAM
// while no held frame waits on a stalled result stream, and offers its final frame after the walk;
// the first frame of a tick leaves once the next due entry or the end of the table is found.
// Throughput: one item at a time in the back part; the front queue holds two more.
// Reset clears the entry count, queue and state; table contents need no clearing.
`default_nettype none

module periodic_frame_scheduler #(
  parameter int unsigned TableDepth = pfs_pkg::TableDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // tdata, from bit 0: now_ms[32], frame_id[29], frame_dlc[4], frame_data[64],
  // interval_ms[16], count_enable[1], count_byte[3], count_shift[3],
  // count_width[4], zero pad[4]
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [pfs_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: action[1]
  input  wire logic                         s_axis_tuser,
  // tdata, from bit 0: entry_index[5], out_id[29], out_dlc[4], out_data[64],
  // zero pad[2]
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [pfs_pkg::OutDataW-1:0]      m_axis_tdata,
  // tuser: kind[2]
  output logic [pfs_pkg::KindW-1:0]         m_axis_tuser,
  // tlast: last
  output logic                              m_axis_tlast
);

  import pfs_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  pfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  pfs_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[tb/pfs_frame_checker.sv]
// Frame checker: predicts scheduler results from the accepted items and compares them.
module pfs_frame_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [pfs_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [pfs_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic [pfs_pkg::KindW-1:0]        m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int unsigned                      pending_o,
  output int unsigned                      errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  // Input item, fields from the lowest bit up are listed last to first
  typedef struct packed {
    logic [3:0]         pad;
    logic [3:0]         cnt_width;
    logic [2:0]         cnt_shift;
    logic [2:0]         ctr_byte;
    logic               cnt_en;
    logic [PeriodW-1:0] interval;
    logic [DataW-1:0]   data;
    logic [DlcW-1:0]    dlc;
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   now;
  } in_word_t;

  // Result item payload
  typedef struct packed {
    logic [1:0]         pad;
    logic [DataW-1:0]   data;
    logic [DlcW-1:0]    dlc;
    logic [IdW-1:0]     id;
    logic [OutIdxW-1:0] idx;
  } out_word_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [OutIdxW-1:0] idx;
    logic [IdW-1:0]     id;
    logic [DlcW-1:0]    dlc;
    logic [DataW-1:0]   data;
    logic               last;
  } frame_rec_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [DlcW-1:0]    dlc;
    logic [DataW-1:0]   data;
    logic [PeriodW-1:0] interval;
    logic [TimeW-1:0]   last_sent;
    logic               cnt_en;
    logic [2:0]         ctr_byte;
    logic [2:0]         cnt_shift;
    logic [3:0]         cnt_width;
  } slot_t;

  slot_t       slots [TableDepth];
  int unsigned filled;
  frame_rec_t  expected_frames [$];
  int unsigned mismatch_count = 0;

  assign errors_o = mismatch_count;

  // Step the rolling counter inside its byte; the field is clipped at bit 7
  function automatic logic [DataW-1:0] bump_counter(input logic [DataW-1:0] data,
                                                    input logic en,
                                                    input logic [2:0] bsel,
                                                    input logic [2:0] sh,
                                                    input logic [3:0] w);
    int unsigned wid;
    logic [7:0]  span;
    logic [7:0]  field_mask;
    logic [7:0]  lane;
    logic [7:0]  cnt;
    if (!en) return data;
    wid        = (w > 4'd8) ? 8 : int'(w);
    span       = 8'((16'd1 << wid) - 16'd1);
    field_mask = 8'(16'(span) << sh);
    lane       = data[bsel*8 +: 8];
    cnt        = (((lane & field_mask) >> sh) + 8'd1) & (field_mask >> sh);
    lane       = (lane & ~field_mask) | 8'(cnt << sh);
    data[bsel*8 +: 8] = lane;
    return data;
  endfunction

  // Work out the results one accepted item causes and queue them
  task automatic apply_item(input logic act, input in_word_t w);
    frame_rec_t     r;
    int unsigned    n_due;
    logic [TimeW-1:0] due_at;
    r = '0;
    n_due = 0;
    if (act == ActionLoad) begin
      r.last = 1'b1;
      if (filled >= TableDepth) begin
        r.kind = KindRefuse;
      end else begin
        slots[filled].id        = w.id;
        slots[filled].dlc       = w.dlc;
        slots[filled].data      = w.data;
        slots[filled].interval  = w.interval;
        slots[filled].last_sent = '0;
        slots[filled].cnt_en    = w.cnt_en;
        slots[filled].ctr_byte  = w.ctr_byte;
        slots[filled].cnt_shift = w.cnt_shift;
        slots[filled].cnt_width = w.cnt_width;
        r.kind = KindAccept;
        r.idx  = OutIdxW'(filled);
        filled++;
      end
      expected_frames.push_back(r);
    end else begin
      // walk the table in slot order, sending every due entry
      for (int unsigned k = 0; k < filled; k++) begin
        due_at = slots[k].last_sent + TimeW'(slots[k].interval);
        if (w.now >= due_at) begin
          slots[k].data = bump_counter(slots[k].data, slots[k].cnt_en, slots[k].ctr_byte,
                                       slots[k].cnt_shift, slots[k].cnt_width);
          slots[k].last_sent = w.now;
          r.kind = KindFrame;
          r.idx  = OutIdxW'(k);
          r.id   = slots[k].id;
          r.dlc  = slots[k].dlc;
          r.data = slots[k].data;
          r.last = 1'b0;
          expected_frames.push_back(r);
          n_due++;
        end
      end
      // mark the final frame of this tick
      if (n_due > 0) begin
        r = expected_frames.pop_back();
        r.last = 1'b1;
        expected_frames.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Watch both channels at every edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_rec_t want;
    out_word_t  seen;
    if (!rst_ni) begin
      filled = 0;
      expected_frames.delete();
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(s_axis_tuser, in_word_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = out_word_t'(m_axis_tdata);
        if (expected_frames.size() == 0) begin
          $error("unexpected result: kind %0d index %0d", m_axis_tuser, seen.idx);
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("kind", DataW'(want.kind), DataW'(m_axis_tuser));
          check_field("entry_index", DataW'(want.idx), DataW'(seen.idx));
          check_field("out_id", DataW'(want.id), DataW'(seen.id));
          check_field("out_dlc", DataW'(want.dlc), DataW'(seen.dlc));
          check_field("out_data", want.data, seen.data);
          check_field("last", DataW'(want.last), DataW'(m_axis_tlast));
        end
      end
      pending_o <= expected_frames.size();
    end
  end

endmodule

[tb/tb_periodic_frame_scheduler.sv]
// Testbench top: drives loads and ticks into the scheduler and gives the verdict.
module tb_periodic_frame_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  localparam int unsigned RandomItems = 215;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [KindW-1:0]      m_axis_tuser;
  logic                  m_axis_tlast;
  int unsigned           pending;
  int unsigned           mismatches;

  logic [TimeW-1:0]      now_ms;
  int unsigned           loads_sent;
  bit                    src_calm;

  periodic_frame_scheduler u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  pfs_frame_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .pending_o    (pending),
    .errors_o     (mismatches)
  );

  always #10 clk_i = ~clk_i;

  // Offer one item after a random gap and hold it until accepted
  task automatic offer(input logic act, input logic [InDataW-1:0] word);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ActionLoad) loads_sent++;
  endtask

  task automatic send_load(input logic [IdW-1:0] id, input logic [DlcW-1:0] dlc,
                           input logic [DataW-1:0] data, input logic [PeriodW-1:0] iv,
                           input logic en, input logic [2:0] bsel,
                           input logic [2:0] sh, input logic [3:0] w);
    offer(ActionLoad, {4'b0, w, sh, bsel, en, iv, data, dlc, id, TimeW'($urandom)});
  endtask

  // Fill the unused load fields with noise; the block must ignore them
  task automatic send_tick(input logic [TimeW-1:0] now);
    offer(ActionTick, {4'b0, 4'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                       16'($urandom), $urandom, $urandom, 4'($urandom),
                       29'($urandom), now});
  endtask

  task automatic send_random_load();
    int unsigned       pick;
    logic [PeriodW-1:0] iv;
    logic [3:0]        w;
    logic [DlcW-1:0]   dlc;
    pick = $urandom_range(0, 9);
    if (pick < 7) iv = PeriodW'($urandom_range(0, 40));
    else if (pick < 9) iv = PeriodW'($urandom_range(0, 3));
    else iv = PeriodW'($urandom);
    w   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    dlc = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    send_load(IdW'($urandom), dlc, {$urandom, $urandom}, iv,
              1'($urandom_range(0, 3) != 0), 3'($urandom), 3'($urandom), w);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned pick;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActionLoad;
    loads_sent = 0;
    src_calm   = 1'b0;
    now_ms     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table
    send_tick(32'd0);
    // extremes: all-ones frame with full-byte counter in the top byte
    send_load(29'h1FFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b1, 3'd7, 3'd0, 4'd8);
    // all-zero frame, counter disabled, longest period
    send_load(29'h0, 4'd0, 64'h0, 16'hFFFF, 1'b0, 3'd0, 3'd0, 4'd0);
    // counter field crossing bit 7
    send_load(29'h0ABC_DEF, 4'd15, 64'h0123_4567_89AB_CDEF, 16'd0, 1'b1, 3'd0, 3'd7, 4'd3);
    // zero-width counter, DLC above eight
    send_load(29'h0AAA_AAAA, 4'd9, 64'hFEDC_BA98_7654_3210, 16'd5, 1'b1, 3'd3, 3'd2, 4'd0);
    // counter width over eight
    send_load(29'h1555_5555, 4'd1, 64'h5A5A_A5A5_3C3C_C3C3, 16'd1, 1'b1, 3'd5, 3'd1, 4'd15);
    // nibble counter about to wrap
    send_load(29'h100, 4'd4, 64'h0000_0000_00E0_0000, 16'd2, 1'b1, 3'd2, 3'd4, 4'd4);
    send_tick(32'd0);
    send_tick(32'd0);
    send_tick(32'd3);
    send_tick(32'd10);
    send_tick(32'h0000_FFFF);
    send_tick(32'hFFFF_FFFF);
    // due sums wrap past 2^32 here
    send_tick(32'd4);
    now_ms = 32'd4;
    drain();

    // random mix of loads and advancing ticks
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain();
      if ($urandom_range(0, 99) < 30) begin
        send_random_load();
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 17) now_ms = now_ms + $urandom_range(0, 30);
        else if (pick < 19) now_ms = $urandom;
        else now_ms = now_ms - $urandom_range(0, 100);
        send_tick(now_ms);
      end
    end
    // make sure loads past a full table are seen
    while (loads_sent < TableDepth + 2) send_random_load();

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned got;
    bit          held;
    bit          calm;
    got  = 0;
    held = 1'b0;
    calm = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tready && m_axis_tvalid) begin
        got++;
        if ($urandom_range(0, 24) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (!held && got == 40) begin
          held = 1'b1;
          gap  = 300;
        end
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
